### hdl/assert_macros.svh
// assertion helpers used by sha1_block_compress
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/sha1bc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1bc_pkg
// types, constants and round functions for the sha-1 block compression engine
// ----------------------------------------------------------------------------
package sha1bc_pkg;

    localparam int WORD_W  = 32;
    localparam int IDX_W   = 4;
    localparam int HIDX_W  = 3;
    localparam int NUM_CV  = 5;
    localparam int NUM_MSG = 16;
    localparam int RND_W   = 7;

    typedef logic [WORD_W-1:0] word_t;

    // action codes
    localparam logic ACT_LOAD_CV = 1'b0;
    localparam logic ACT_MSG     = 1'b1;

    localparam logic [IDX_W-1:0]  LAST_MSG_IDX = 4'd15;
    localparam logic [IDX_W-1:0]  CV_LIMIT     = 4'd5;
    localparam logic [HIDX_W-1:0] LAST_CV_IDX  = 3'd4;

    localparam logic [RND_W-1:0] GRP1_START = 7'd20;
    localparam logic [RND_W-1:0] GRP2_START = 7'd40;
    localparam logic [RND_W-1:0] GRP3_START = 7'd60;
    localparam logic [RND_W-1:0] LAST_ROUND = 7'd79;

    localparam word_t K_GRP0 = 32'h5a827999;
    localparam word_t K_GRP1 = 32'h6ed9eba1;
    localparam word_t K_GRP2 = 32'h8f1bbcdc;
    localparam word_t K_GRP3 = 32'hca62c1d6;

    typedef enum logic [1:0] {
        GRP_CHOOSE,
        GRP_PARITY_LO,
        GRP_MAJORITY,
        GRP_PARITY_HI
    } grp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } st_t;

    typedef struct packed {
        logic load;
        logic round_en;
        logic add_en;
        grp_t grp;
    } ctrl_t;

    typedef struct packed {
        logic               en;
        logic [HIDX_W-1:0]  idx;
        word_t              data;
    } cv_wr_t;

    function automatic word_t rotl1(input word_t v);
        return {v[WORD_W-2:0], v[WORD_W-1]};
    endfunction

    function automatic word_t rotl5(input word_t v);
        return {v[WORD_W-6:0], v[WORD_W-1:WORD_W-5]};
    endfunction

    function automatic word_t rotl30(input word_t v);
        return {v[1:0], v[WORD_W-1:2]};
    endfunction

    function automatic word_t round_fn(input grp_t g, input word_t b, input word_t c,
                                       input word_t d);
        word_t r;
        unique case (g)
            GRP_CHOOSE:   r = (b & c) | (~b & d);
            GRP_MAJORITY: r = (b & c) | (b & d) | (c & d);
            default:      r = b ^ c ^ d;
        endcase
        return r;
    endfunction

    function automatic word_t round_k(input grp_t g);
        word_t r;
        unique case (g)
            GRP_CHOOSE:    r = K_GRP0;
            GRP_PARITY_LO: r = K_GRP1;
            GRP_MAJORITY:  r = K_GRP2;
            default:       r = K_GRP3;
        endcase
        return r;
    endfunction

endpackage

### hdl/sha1bc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1bc channel interfaces
// valid/ready channels for input words and output hash words
// ----------------------------------------------------------------------------
interface sha1bc_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [3:0]  word_index;
    logic [31:0] data_word;

    modport source (output valid, output action, output word_index, output data_word,
                    input ready);
    modport sink   (input valid, input action, input word_index, input data_word,
                    output ready);
endinterface

interface sha1bc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_word;
    logic [2:0]  hash_index;
    logic        last_word;

    modport source (output valid, output hash_word, output hash_index, output last_word,
                    input ready);
    modport sink   (input valid, input hash_word, input hash_index, input last_word,
                    output ready);
endinterface

### hdl/sha1_block_compress.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_block_compress
// sha-1 compression of one 512-bit block into a five-word chaining value
// ----------------------------------------------------------------------------
// Chaining words (action 0, index 0..4) and message words (action 1, index
// 0..15) are taken one per cycle while idle; chaining loads with index 5..15
// are dropped. Storing message word 15 starts a compression: a load state copies
// the stored block into the schedule window, a round state runs 80 rounds, one
// per cycle, on the shared round adder, an add state adds into the chaining
// value, and the five updated words then leave A through E, one per output
// transaction, E marked last. After word 15 no input is taken until the last
// hash word leaves, output stalls included. Stored message words persist across
// blocks.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha1_block_compress (
    input  logic          clk,
    input  logic          rst_n,
    sha1bc_in_if.sink     msg_in,
    sha1bc_out_if.source  hash_out
);
    import sha1bc_pkg::*;

    st_t               state_reg, state_next;
    logic [RND_W-1:0]  rnd_cnt_reg;
    logic [HIDX_W-1:0] out_cnt_reg;
    ctrl_t             ctrl;
    cv_wr_t            cv_wr;
    logic              in_xact, out_xact, start_blk;
    word_t             sched_word;

    assign in_xact   = msg_in.valid && msg_in.ready;
    assign out_xact  = hash_out.valid && hash_out.ready;
    assign start_blk = in_xact && (msg_in.action == ACT_MSG)
                       && (msg_in.word_index == LAST_MSG_IDX);

    assign cv_wr.en   = in_xact && (msg_in.action == ACT_LOAD_CV)
                        && (msg_in.word_index < CV_LIMIT);
    assign cv_wr.idx  = msg_in.word_index[HIDX_W-1:0];
    assign cv_wr.data = msg_in.data_word;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (start_blk) state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_ROUND;
            ST_ROUND: if (rnd_cnt_reg == LAST_ROUND) state_next = ST_ADD;
            ST_ADD:   state_next = ST_EMIT;
            ST_EMIT:  if (out_xact && (out_cnt_reg == LAST_CV_IDX)) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        msg_in.ready   = 1'b0;
        hash_out.valid = 1'b0;
        ctrl.load      = 1'b0;
        ctrl.round_en  = 1'b0;
        ctrl.add_en    = 1'b0;
        unique case (state_reg)
            ST_IDLE:  msg_in.ready   = 1'b1;
            ST_LOAD:  ctrl.load      = 1'b1;
            ST_ROUND: ctrl.round_en  = 1'b1;
            ST_ADD:   ctrl.add_en    = 1'b1;
            ST_EMIT:  hash_out.valid = 1'b1;
            default:  msg_in.ready   = 1'b0;
        endcase

        priority if (rnd_cnt_reg < GRP1_START) ctrl.grp = GRP_CHOOSE;
        else if (rnd_cnt_reg < GRP2_START)     ctrl.grp = GRP_PARITY_LO;
        else if (rnd_cnt_reg < GRP3_START)     ctrl.grp = GRP_MAJORITY;
        else                                   ctrl.grp = GRP_PARITY_HI;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rnd_cnt_reg <= '0;
            out_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctrl.load)
            begin
                rnd_cnt_reg <= '0;
            end
            else if (ctrl.round_en)
            begin
                rnd_cnt_reg <= rnd_cnt_reg + RND_W'(1);
            end
            if (ctrl.add_en)
            begin
                out_cnt_reg <= '0;
            end
            else if (out_xact)
            begin
                out_cnt_reg <= out_cnt_reg + HIDX_W'(1);
            end
        end
    end

    sha1bc_sched u_sched (
        .clk         (clk),
        .msg_wr_en   (in_xact && (msg_in.action == ACT_MSG)),
        .msg_wr_idx  (msg_in.word_index),
        .msg_wr_data (msg_in.data_word),
        .ctrl        (ctrl),
        .sched_word  (sched_word)
    );

    sha1bc_round u_round (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .cv_wr      (cv_wr),
        .sched_word (sched_word),
        .rd_idx     (out_cnt_reg),
        .rd_word    (hash_out.hash_word)
    );

    assign hash_out.hash_index = out_cnt_reg;
    assign hash_out.last_word  = (out_cnt_reg == LAST_CV_IDX);

    `ASSERT_CLK_RST(a_start_load, clk, rst_n, start_blk |=> (state_reg == ST_LOAD), "word 15 did not start a block")
    `ASSERT_CLK_RST(a_last_idle, clk, rst_n, (out_xact && hash_out.last_word) |=> msg_in.ready, "engine not idle after last hash word")
    `ASSERT_CLK_RST(a_rnd_range, clk, rst_n, (state_reg == ST_ROUND) |-> (rnd_cnt_reg <= LAST_ROUND), "round counter out of range")
    `ASSERT_CLK_RST(a_out_range, clk, rst_n, hash_out.valid |-> (out_cnt_reg <= LAST_CV_IDX), "hash index out of range")
    `ASSERT_CLK(a_no_overlap, clk, !(hash_out.valid && msg_in.ready), "input taken while emitting")

endmodule

### hdl/sha1bc_sched.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1bc_sched
// message word store and sliding 16-word schedule window
// ----------------------------------------------------------------------------
module sha1bc_sched (
    input  logic                  clk,
    input  logic                  msg_wr_en,
    input  logic [3:0]            msg_wr_idx,
    input  logic [31:0]           msg_wr_data,
    input  sha1bc_pkg::ctrl_t     ctrl,
    output logic [31:0]           sched_word
);
    import sha1bc_pkg::*;

    word_t msg_mem_reg [NUM_MSG];
    word_t win_reg     [NUM_MSG];
    word_t win_new;

    always_ff @(posedge clk)
    begin
        if (msg_wr_en)
        begin
            msg_mem_reg[msg_wr_idx] <= msg_wr_data;
        end
    end

    // w[t+16] = rotl1(w[t+13] ^ w[t+8] ^ w[t+2] ^ w[t])
    assign win_new = rotl1(win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0]);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            for (int i = 0; i < NUM_MSG; i++)
            begin
                win_reg[i] <= msg_mem_reg[i];
            end
        end
        else if (ctrl.round_en)
        begin
            for (int i = 0; i < NUM_MSG - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[NUM_MSG-1] <= win_new;
        end
    end

    assign sched_word = win_reg[0];

endmodule

### hdl/sha1bc_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1bc_round
// chaining value registers and the shared one-round-per-cycle datapath
// ----------------------------------------------------------------------------
module sha1bc_round (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sha1bc_pkg::ctrl_t     ctrl,
    input  sha1bc_pkg::cv_wr_t    cv_wr,
    input  logic [31:0]           sched_word,
    input  logic [2:0]            rd_idx,
    output logic [31:0]           rd_word
);
    import sha1bc_pkg::*;

    word_t chain_reg [NUM_CV];
    word_t a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t a_next;

    assign a_next = rotl5(a_reg) + round_fn(ctrl.grp, b_reg, c_reg, d_reg) + e_reg
                    + sched_word + round_k(ctrl.grp);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
        else if (ctrl.round_en)
        begin
            a_reg <= a_next;
            b_reg <= a_reg;
            c_reg <= rotl30(b_reg);
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CV; i++)
            begin
                chain_reg[i] <= '0;
            end
        end
        else if (ctrl.add_en)
        begin
            chain_reg[0] <= chain_reg[0] + a_reg;
            chain_reg[1] <= chain_reg[1] + b_reg;
            chain_reg[2] <= chain_reg[2] + c_reg;
            chain_reg[3] <= chain_reg[3] + d_reg;
            chain_reg[4] <= chain_reg[4] + e_reg;
        end
        else if (cv_wr.en)
        begin
            chain_reg[cv_wr.idx] <= cv_wr.data;
        end
    end

    assign rd_word = chain_reg[rd_idx];

endmodule
